// ===== rtl/contiguous_run_pool_allocator_assert.svh =====
// Assertion macros for the contiguous run pool allocator checker.
`ifndef CONTIGUOUS_RUN_POOL_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_RUN_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CRPA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crpa check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CRPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crpa check failed");

`endif

// ===== rtl/crpa_pkg.sv =====
// Shared types, codes and sizes for the contiguous run pool allocator.
package crpa_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int BYTES_W   = 16;
    localparam int OFS_W     = 22;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] CMD_REQUEST = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_ZERO   = 2'd1;
    localparam logic [1:0] STAT_NOROOM = 2'd2;
    localparam logic [1:0] STAT_BADREL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES = 2'd1;

    localparam logic [CNT_W-1:0]   CAPACITY_RESET   = 7'd64;
    localparam logic [BYTES_W-1:0] SLOT_BYTES_RESET = 16'd4;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [CNT_W-1:0]  run_length;
        logic [SLOT_W-1:0] slot_index;
    } req_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] start_slot;
        logic [OFS_W-1:0]  byte_offset;
        logic [CNT_W-1:0]  live_count;
    } rsp_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_CHECK,
        S_TAKE,
        S_BUMP,
        S_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic decode;
        logic scan_step;
        logic take_init;
        logic take_step;
        logic bump;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       len_zero;
        logic       freed_any;
        logic       scan_done;
        logic       run_fits;
        logic       take_last;
        logic       out_free;
    } dp_stat_t;

endpackage

// ===== rtl/contiguous_run_pool_allocator.sv =====
// Top level of the contiguous run pool allocator: sequencer plus datapath.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_item (cmd, run_length, slot_index)
//   rsp      out        rsp_valid/rsp_stall   rsp_item (status, start_slot, byte_offset,
//                                                       live_count)
//   cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One transfer at a time. Release, clear, unused and zero-length commands go from decode
// to the result stage; a request with no freed slots bumps first. With freed slots the
// map is scanned one bit a cycle, then the longest run is taken or the request bumps.
// Reset clears the pool at once; capacity returns to 64, slot size to 4 bytes.
// A stalled result holds the block in its result stage, so req stays stalled until rsp
// takes the register.
module contiguous_run_pool_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  crpa_pkg::req_item_t             req_item,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output crpa_pkg::rsp_item_t             rsp_item,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [crpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crpa_pkg::BYTES_W-1:0]    cfg_data
);
    import crpa_pkg::*;

    ctl_cmd_t ctl;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    crpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    crpa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== rtl/crpa_ctrl.sv =====
// Sequencer for the allocator: decode, freed-map scan, run take, bump, result.
module crpa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  crpa_pkg::dp_stat_t  stat,
    output crpa_pkg::ctl_cmd_t  ctl
);
    import crpa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.cmd == CMD_REQUEST && !stat.len_zero)
                begin
                    state_next = stat.freed_any ? S_SCAN : S_BUMP;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = stat.run_fits ? S_TAKE : S_BUMP;
            end
            S_TAKE:
            begin
                if (stat.take_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_BUMP:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl       = '0;
        req_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req_stall   = 1'b0;
                ctl.capture = req_valid;
            end
            S_DECODE:
            begin
                ctl.decode = 1'b1;
            end
            S_SCAN:
            begin
                ctl.scan_step = !stat.scan_done;
            end
            S_CHECK:
            begin
                ctl.take_init = stat.run_fits;
            end
            S_TAKE:
            begin
                ctl.take_step = 1'b1;
            end
            S_BUMP:
            begin
                ctl.bump = 1'b1;
            end
            S_OUT:
            begin
                ctl.load_out = stat.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

// ===== rtl/crpa_datapath.sv =====
// Pool state, freed-map scan registers, configuration and result register.
module crpa_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  crpa_pkg::ctl_cmd_t                  ctl,
    output crpa_pkg::dp_stat_t                  stat,
    input  crpa_pkg::req_item_t                 req_item,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output crpa_pkg::rsp_item_t                 rsp_item,
    input  logic                                cfg_valid,
    input  logic [crpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [crpa_pkg::BYTES_W-1:0]        cfg_data
);
    import crpa_pkg::*;

    logic [MAX_SLOTS-1:0] freed_map_reg,   freed_map_next;
    logic [CNT_W-1:0]     high_mark_reg,   high_mark_next;
    logic [CNT_W-1:0]     live_slots_reg,  live_slots_next;
    logic [CNT_W-1:0]     freed_count_reg, freed_count_next;
    logic [CNT_W-1:0]     capacity_reg,    capacity_next;
    logic [BYTES_W-1:0]   slot_bytes_reg,  slot_bytes_next;
    logic                 rsp_valid_reg,   rsp_valid_next;

    req_item_t            item_reg,        item_next;
    logic [1:0]           status_reg,      status_next;
    logic [SLOT_W-1:0]    start_reg,       start_next;
    logic [CNT_W-1:0]     scan_reg,        scan_next;
    logic [CNT_W-1:0]     cur_len_reg,     cur_len_next;
    logic [SLOT_W-1:0]    cur_at_reg,      cur_at_next;
    logic [CNT_W-1:0]     best_len_reg,    best_len_next;
    logic [SLOT_W-1:0]    best_at_reg,     best_at_next;
    logic [CNT_W-1:0]     take_rem_reg,    take_rem_next;
    rsp_item_t            rsp_item_reg,    rsp_item_next;

    logic [SLOT_W-1:0]    scan_idx;
    logic [SLOT_W-1:0]    run_at;
    logic [CNT_W-1:0]     run_len;
    logic [CNT_W-1:0]     eff_cap;
    logic [CNT_W:0]       bump_top;
    logic                 rel_bad;
    logic [OFS_W-1:0]     offset;

    assign scan_idx = scan_reg[SLOT_W-1:0];
    assign run_at   = (cur_len_reg == '0) ? scan_idx : cur_at_reg;
    assign run_len  = cur_len_reg + CNT_W'(1);
    assign eff_cap  = (capacity_reg > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : capacity_reg;
    assign bump_top = {1'b0, high_mark_reg} + {1'b0, item_reg.run_length};
    assign rel_bad  = ({1'b0, item_reg.slot_index} >= high_mark_reg)
                      || freed_map_reg[item_reg.slot_index]
                      || (live_slots_reg == '0);
    assign offset   = OFS_W'(start_reg) * OFS_W'(slot_bytes_reg);

    assign stat.cmd       = item_reg.cmd;
    assign stat.len_zero  = (item_reg.run_length == '0);
    assign stat.freed_any = (freed_count_reg != '0);
    assign stat.scan_done = (scan_reg >= high_mark_reg);
    assign stat.run_fits  = (best_len_reg >= item_reg.run_length);
    assign stat.take_last = (take_rem_reg == CNT_W'(1));
    assign stat.out_free  = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    always_comb
    begin
        freed_map_next   = freed_map_reg;
        high_mark_next   = high_mark_reg;
        live_slots_next  = live_slots_reg;
        freed_count_next = freed_count_reg;
        capacity_next    = capacity_reg;
        slot_bytes_next  = slot_bytes_reg;
        rsp_valid_next   = rsp_valid_reg;
        item_next        = item_reg;
        status_next      = status_reg;
        start_next       = start_reg;
        scan_next        = scan_reg;
        cur_len_next     = cur_len_reg;
        cur_at_next      = cur_at_reg;
        best_len_next    = best_len_reg;
        best_at_next     = best_at_reg;
        take_rem_next    = take_rem_reg;
        rsp_item_next    = rsp_item_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CAPACITY:   capacity_next   = cfg_data[CNT_W-1:0];
                REG_SLOT_BYTES: slot_bytes_next = cfg_data;
                default:        ;
            endcase
        end

        if (ctl.capture)
        begin
            item_next   = req_item;
            status_next = STAT_OK;
            start_next  = '0;
        end

        if (ctl.decode)
        begin
            case (item_reg.cmd)
                CMD_REQUEST:
                begin
                    if (item_reg.run_length == '0)
                    begin
                        status_next = STAT_ZERO;
                    end
                    else
                    begin
                        scan_next     = '0;
                        cur_len_next  = '0;
                        cur_at_next   = '0;
                        best_len_next = '0;
                        best_at_next  = '0;
                    end
                end
                CMD_RELEASE:
                begin
                    if (rel_bad)
                    begin
                        status_next = STAT_BADREL;
                    end
                    else
                    begin
                        live_slots_next = live_slots_reg - CNT_W'(1);
                        if (CNT_W'(item_reg.slot_index) + CNT_W'(1) == high_mark_reg)
                        begin
                            high_mark_next = high_mark_reg - CNT_W'(1);
                        end
                        else
                        begin
                            freed_map_next[item_reg.slot_index] = 1'b1;
                            freed_count_next = freed_count_reg + CNT_W'(1);
                        end
                    end
                end
                CMD_CLEAR:
                begin
                    freed_map_next   = '0;
                    high_mark_next   = '0;
                    live_slots_next  = '0;
                    freed_count_next = '0;
                end
                default: ;
            endcase
        end

        if (ctl.scan_step)
        begin
            scan_next = scan_reg + CNT_W'(1);
            if (freed_map_reg[scan_idx])
            begin
                cur_at_next  = run_at;
                cur_len_next = run_len;
                if (run_len > best_len_reg)
                begin
                    best_len_next = run_len;
                    best_at_next  = run_at;
                end
            end
            else
            begin
                cur_len_next = '0;
            end
        end

        if (ctl.take_init)
        begin
            freed_count_next = freed_count_reg - item_reg.run_length;
            live_slots_next  = live_slots_reg + item_reg.run_length;
            start_next       = best_at_reg;
            scan_next        = CNT_W'(best_at_reg);
            take_rem_next    = item_reg.run_length;
        end

        if (ctl.take_step)
        begin
            freed_map_next[scan_idx] = 1'b0;
            scan_next     = scan_reg + CNT_W'(1);
            take_rem_next = take_rem_reg - CNT_W'(1);
        end

        if (ctl.bump)
        begin
            if (bump_top <= {1'b0, eff_cap})
            begin
                start_next      = high_mark_reg[SLOT_W-1:0];
                high_mark_next  = bump_top[CNT_W-1:0];
                live_slots_next = live_slots_reg + item_reg.run_length;
            end
            else
            begin
                status_next = STAT_NOROOM;
            end
        end

        if (ctl.load_out)
        begin
            rsp_valid_next            = 1'b1;
            rsp_item_next.status      = status_reg;
            rsp_item_next.start_slot  = start_reg;
            rsp_item_next.byte_offset = offset;
            rsp_item_next.live_count  = live_slots_reg;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freed_map_reg   <= '0;
            high_mark_reg   <= '0;
            live_slots_reg  <= '0;
            freed_count_reg <= '0;
            capacity_reg    <= CAPACITY_RESET;
            slot_bytes_reg  <= SLOT_BYTES_RESET;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            freed_map_reg   <= freed_map_next;
            high_mark_reg   <= high_mark_next;
            live_slots_reg  <= live_slots_next;
            freed_count_reg <= freed_count_next;
            capacity_reg    <= capacity_next;
            slot_bytes_reg  <= slot_bytes_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        status_reg   <= status_next;
        start_reg    <= start_next;
        scan_reg     <= scan_next;
        cur_len_reg  <= cur_len_next;
        cur_at_reg   <= cur_at_next;
        best_len_reg <= best_len_next;
        best_at_reg  <= best_at_next;
        take_rem_reg <= take_rem_next;
        rsp_item_reg <= rsp_item_next;
    end

endmodule

// ===== rtl/crpa_checker.sv =====
// Port-level checks for the contiguous run pool allocator, bound to the top level.
`include "contiguous_run_pool_allocator_assert.svh"

module crpa_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_stall,
    input logic                 rsp_valid,
    input logic                 rsp_stall,
    input crpa_pkg::rsp_item_t  rsp_item
);
    import crpa_pkg::*;

    // an accepted item keeps the block busy for at least the next cycle
    `CRPA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

    // only a granted run carries a start slot and offset
    `CRPA_ASSERT_NOW(a_fail_zero_start, rsp_valid && rsp_item.status != STAT_OK,
                     rsp_item.start_slot == '0 && rsp_item.byte_offset == '0)

    `CRPA_ASSERT_NOW(a_live_bounded, rsp_valid,
                     rsp_item.live_count <= CNT_W'(MAX_SLOTS))

    `CRPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
                      rsp_valid && $stable(rsp_item))

endmodule

bind contiguous_run_pool_allocator crpa_checker u_crpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
);

// ===== bench/contiguous_run_pool_allocator_tb.sv =====
// Self-checking testbench for the contiguous run pool allocator: predictor, scoreboard, stimulus.
module contiguous_run_pool_allocator_tb;

    import crpa_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;

    class pool_scoreboard;
        bit [MAX_SLOTS-1:0] freed;
        int                 high_mark;
        int                 live_slots;
        int                 freed_count;
        int                 capacity;
        int                 slot_bytes;
        rsp_item_t          due_responses[$];
        int                 errors;
        int                 results;
        int                 seen_status[4];

        function new();
            freed       = '0;
            high_mark   = 0;
            live_slots  = 0;
            freed_count = 0;
            capacity    = CAPACITY_RESET;
            slot_bytes  = SLOT_BYTES_RESET;
            errors      = 0;
            results     = 0;
            foreach (seen_status[i])
                seen_status[i] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTES_W-1:0] data);
            if (idx == REG_CAPACITY)
                capacity = data[CNT_W-1:0];
            else if (idx == REG_SLOT_BYTES)
                slot_bytes = data;
        endfunction

        function int pending();
            return due_responses.size();
        endfunction

        // Applies one command to the pool model and returns the response it gives.
        function rsp_item_t advance(req_item_t it);
            rsp_item_t   r;
            logic [1:0]  st;
            logic [31:0] ofs;
            int          start, len, s, i, cap;
            int          best_len, best_at, cur_len, cur_at;
            bit          granted;
            st      = STAT_OK;
            start   = 0;
            granted = 1'b0;
            case (it.cmd)
                CMD_REQUEST:
                begin
                    len = it.run_length;
                    if (len == 0)
                        st = STAT_ZERO;
                    else
                    begin
                        if (freed_count != 0)
                        begin
                            best_len = 0;
                            best_at  = 0;
                            cur_len  = 0;
                            cur_at   = 0;
                            for (i = 0; i < high_mark; i++)
                            begin
                                if (freed[i])
                                begin
                                    if (cur_len == 0)
                                        cur_at = i;
                                    cur_len++;
                                    if (cur_len > best_len)
                                    begin
                                        best_len = cur_len;
                                        best_at  = cur_at;
                                    end
                                end
                                else
                                    cur_len = 0;
                            end
                            if (best_len >= len)
                            begin
                                for (i = 0; i < len; i++)
                                    freed[best_at + i] = 1'b0;
                                freed_count -= len;
                                live_slots  += len;
                                start   = best_at;
                                granted = 1'b1;
                            end
                        end
                        if (!granted)
                        begin
                            cap = (capacity > MAX_SLOTS) ? MAX_SLOTS : capacity;
                            if (high_mark + len <= cap)
                            begin
                                start      = high_mark;
                                high_mark += len;
                                live_slots += len;
                            end
                            else
                                st = STAT_NOROOM;
                        end
                    end
                end
                CMD_RELEASE:
                begin
                    s = it.slot_index;
                    if (s >= high_mark || freed[s] || live_slots == 0)
                        st = STAT_BADREL;
                    else
                    begin
                        live_slots--;
                        if (s + 1 == high_mark)
                            high_mark--;
                        else
                        begin
                            freed[s] = 1'b1;
                            freed_count++;
                        end
                    end
                end
                CMD_CLEAR:
                begin
                    freed       = '0;
                    high_mark   = 0;
                    live_slots  = 0;
                    freed_count = 0;
                end
                default: ;
            endcase
            ofs           = start * slot_bytes;
            r.status      = st;
            r.start_slot  = start[SLOT_W-1:0];
            r.byte_offset = ofs[OFS_W-1:0];
            r.live_count  = live_slots[CNT_W-1:0];
            return r;
        endfunction

        task note_request(req_item_t it);
            due_responses = {due_responses, advance(it)};
        endtask

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_response(rsp_item_t got);
            rsp_item_t want;
            results++;
            seen_status[got.status]++;
            if (due_responses.size() == 0)
            begin
                report("response with no command outstanding");
                return;
            end
            want = due_responses.pop_front();
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.start_slot !== want.start_slot)
                report($sformatf("start_slot got %0d want %0d", got.start_slot,
                                 want.start_slot));
            if (got.byte_offset !== want.byte_offset)
                report($sformatf("byte_offset got %0d want %0d", got.byte_offset,
                                 want.byte_offset));
            if (got.live_count !== want.live_count)
                report($sformatf("live_count got %0d want %0d", got.live_count,
                                 want.live_count));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_item_t            req_item = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_item_t            rsp_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTES_W-1:0]   cfg_data = '0;

    pool_scoreboard sb;
    int             idle_pct = 22;
    int             sent = 0;
    int             settings = 0;

    contiguous_run_pool_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp_item);
        rsp_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    function req_item_t mk(logic [1:0] c, int len, int slot);
        req_item_t it;
        it.cmd        = c;
        it.run_length = CNT_W'(len);
        it.slot_index = SLOT_W'(slot);
        return it;
    endfunction

    task send_item(input req_item_t it);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(it);
        sent++;
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTES_W-1:0] data,
                   input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    // Hold off the sender until every response is back, then let the block go idle.
    task quiesce();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task set_pool(input int cap, input bit cap_noise, input logic [BYTES_W-1:0] bytes);
        logic [BYTES_W-1:0] data;
        quiesce();
        data = BYTES_W'(cap);
        if (cap_noise)
            data[BYTES_W-1:CNT_W] = (BYTES_W-CNT_W)'($urandom);
        write_reg(REG_CAPACITY, data, 1'b0);
        write_reg(REG_SLOT_BYTES, bytes, 1'b1);
        settings++;
    endtask

    // Mostly allocate/release traffic aimed at live slots, with some noise.
    function req_item_t pick_item();
        req_item_t it;
        int        roll, s;
        it.cmd        = CMD_REQUEST;
        it.run_length = CNT_W'($urandom);
        it.slot_index = SLOT_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 45)
            it.run_length = CNT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                               : $urandom_range(1, 4));
        else if (roll < 85)
        begin
            it.cmd = CMD_RELEASE;
            if (sb.live_slots > 0 && $urandom_range(0, 9) != 0)
            begin
                if ($urandom_range(0, 3) == 0 && !sb.freed[sb.high_mark - 1])
                    s = sb.high_mark - 1;
                else
                begin
                    s = $urandom_range(0, sb.high_mark - 1);
                    while (sb.freed[s])
                        s = $urandom_range(0, sb.high_mark - 1);
                end
                it.slot_index = SLOT_W'(s);
            end
        end
        else if (roll < 91)
            it.run_length = CNT_W'($urandom);
        else if (roll < 94)
            it.run_length = '0;
        else if (roll < 97)
            it.cmd = CMD_SPARE;
        else
            it.cmd = CMD_CLEAR;
        return it;
    endfunction

    task random_phase(input int count, input int pct);
        int n;
        idle_pct = pct;
        for (n = 0; n < count; n++)
            send_item(pick_item());
        idle_pct = 22;
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: capacity 64, 4-byte slots
        send_item(mk(CMD_REQUEST, 0, 0));
        send_item(mk(CMD_RELEASE, 0, 0));
        send_item(mk(CMD_REQUEST, 1, 0));
        send_item(mk(CMD_REQUEST, 3, 0));
        send_item(mk(CMD_RELEASE, 0, 2));
        send_item(mk(CMD_RELEASE, 0, 2));
        send_item(mk(CMD_RELEASE, 0, 1));
        send_item(mk(CMD_REQUEST, 2, 0));
        send_item(mk(CMD_RELEASE, 0, 3));
        send_item(mk(CMD_RELEASE, 0, 1));
        send_item(mk(CMD_RELEASE, 0, 2));
        send_item(mk(CMD_RELEASE, 0, 63));
        send_item(mk(CMD_SPARE, 127, 63));
        send_item(mk(CMD_REQUEST, 127, 0));
        send_item(mk(CMD_REQUEST, 2, 0));
        send_item(mk(CMD_REQUEST, 1, 0));
        send_item(mk(CMD_CLEAR, 0, 0));
        send_item(mk(CMD_REQUEST, 64, 0));
        send_item(mk(CMD_RELEASE, 0, 0));

        // capacity dropped under the mark: reuse works, bumping does not
        set_pool(4, 1'b0, 16'd4);
        send_item(mk(CMD_REQUEST, 1, 5));
        send_item(mk(CMD_REQUEST, 1, 0));

        // largest byte offset
        set_pool(64, 1'b0, 16'hFFFF);
        send_item(mk(CMD_CLEAR, 0, 0));
        send_item(mk(CMD_REQUEST, 63, 0));
        send_item(mk(CMD_REQUEST, 1, 0));

        set_pool(64, 1'b0, 16'd4);
        random_phase(70, 22);
        set_pool(1, 1'b0, 16'hFFFF);
        random_phase(50, 22);
        set_pool(64, 1'b1, BYTES_W'($urandom));
        random_phase(100, 0);
        set_pool($urandom_range(1, 64), 1'b0, BYTES_W'($urandom));
        random_phase(60, 22);
        set_pool(0, 1'b1, BYTES_W'($urandom_range(0, 3)));
        random_phase(40, 22);
        set_pool(127, 1'b0, 16'hFFFF);
        random_phase(60, 22);
        set_pool($urandom_range(1, 64), 1'b1, BYTES_W'($urandom));
        random_phase(70, 22);
        set_pool(64, 1'b0, BYTES_W'($urandom));
        random_phase(80, 22);

        quiesce();
        repeat (150) @(posedge clk);
        $display("covered %0d commands and %0d responses over %0d pool settings",
                 sent, sb.results, settings + 1);
        $display("responses by status: ok %0d, zero length %0d, no room %0d, bad release %0d",
                 sb.seen_status[STAT_OK], sb.seen_status[STAT_ZERO],
                 sb.seen_status[STAT_NOROOM], sb.seen_status[STAT_BADREL]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS contiguous_run_pool_allocator");
        else
            $display("FAIL contiguous_run_pool_allocator");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout waiting on the allocator");
        $display("FAIL contiguous_run_pool_allocator");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/crpa_pkg.sv
rtl/crpa_ctrl.sv
rtl/crpa_datapath.sv
rtl/contiguous_run_pool_allocator.sv
rtl/crpa_checker.sv
bench/contiguous_run_pool_allocator_tb.sv
